[hw/rtl/pfi_pkg.sv]
package pfi_pkg;
   localparam int unsigned ChanW = 6;
   localparam int unsigned IdxW = 8;
   localparam int unsigned StepsW = 7;
   localparam int unsigned AccW = 21;
   localparam logic [StepsW-1:0] StepsReset = 7'd32;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef struct packed {
      op_type op;
      logic [IdxW-1:0] index;
      logic [2:0][ChanW-1:0] start;
      logic [2:0][ChanW-1:0] target;
   } req_type;

   typedef struct packed {
      logic [IdxW-1:0] index;
      logic [2:0][ChanW-1:0] rgb;
   } rsp_type;

   // queued work for the back end; load items carry quotient and remainder
   typedef struct packed {
      op_type op;
      logic [IdxW-1:0] index;
      logic [2:0][ChanW-1:0] start;
      logic [2:0][StepsW-1:0] quo;
      logic [2:0][StepsW-1:0] rem;
      logic [2:0] neg;
      logic [StepsW-1:0] steps;
   } work_type;

   function automatic logic [15:0] pack565(input logic [2:0][ChanW-1:0] c);
      pack565 = {c[0][5:1], c[1], c[2][5:1]};
   endfunction
endpackage

[hw/rtl/pfi_if.sv]
interface pfi_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [7:0] entry_index;
   logic [5:0] start_red;
   logic [5:0] start_green;
   logic [5:0] start_blue;
   logic [5:0] target_red;
   logic [5:0] target_green;
   logic [5:0] target_blue;
   modport source(output valid, operation, entry_index, start_red, start_green, start_blue,
      target_red, target_green, target_blue, input ready);
   modport sink(input valid, operation, entry_index, start_red, start_green, start_blue,
      target_red, target_green, target_blue, output ready);
endinterface

interface pfi_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_index;
   logic [5:0] out_red;
   logic [5:0] out_green;
   logic [5:0] out_blue;
   logic [15:0] packed_colour;
   modport source(output valid, out_index, out_red, out_green, out_blue, packed_colour,
      input ready);
   modport sink(input valid, out_index, out_red, out_green, out_blue, packed_colour,
      output ready);
endinterface

interface pfi_csr_if;
   logic valid;
   logic ready;
   logic [6:0] fade_steps;
   modport source(output valid, fade_steps, input ready);
   modport sink(input valid, fade_steps, output ready);
endinterface

[hw/rtl/pfi_front.sv]
module pfi_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  pfi_pkg::req_type in_req,
   input  logic [pfi_pkg::StepsW-1:0] steps,
   output logic out_valid,
   input  logic out_ready,
   output pfi_pkg::work_type out_work
);
   import pfi_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff;
   work_type work_ff;
   logic [2:0][ChanW-1:0] mag_ff;
   logic [2:0] cnt_ff;
   logic [2:0][StepsW-1:0] rem_w;
   logic [2:0][StepsW:0] trial_w;

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);
   assign out_work = work_ff;

   // restoring divide step, one quotient bit per channel per cycle
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         trial_w[c] = {work_ff.rem[c], mag_ff[c][ChanW-1]};
         rem_w[c] = (trial_w[c] >= {1'b0, work_ff.steps}) ?
            StepsW'(trial_w[c] - {1'b0, work_ff.steps}) : trial_w[c][StepsW-1:0];
      end
   end

   // load items divide |start-target| by the step count; steps pass through
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (in_valid) begin
               work_ff.op <= in_req.op;
               work_ff.index <= in_req.index;
               work_ff.start <= in_req.start;
               work_ff.steps <= (steps == '0) ? StepsW'(1) : steps;
               work_ff.quo <= '0;
               work_ff.rem <= '0;
               for (int c = 0; c < 3; c++) begin
                  work_ff.neg[c] <= in_req.target[c] > in_req.start[c];
                  mag_ff[c] <= (in_req.target[c] > in_req.start[c]) ?
                     in_req.target[c] - in_req.start[c] : in_req.start[c] - in_req.target[c];
               end
               cnt_ff <= '0;
               state_ff <= (in_req.op == OP_LOAD) ? S_DIV : S_DONE;
            end
            S_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  work_ff.rem[c] <= rem_w[c];
                  work_ff.quo[c] <= {work_ff.quo[c][StepsW-2:0],
                     (trial_w[c] >= {1'b0, work_ff.steps})};
                  mag_ff[c] <= {mag_ff[c][ChanW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'(ChanW - 1)) state_ff <= S_DONE;
            end
            S_DONE: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_done_no_ready: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !in_ready) else $error("front takes request while holding one");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == 3'(ChanW - 1)) |=> out_valid)
      else $error("divide did not finish");
   a_steps_nz: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> work_ff.steps != '0) else $error("zero step count");
endmodule

[hw/rtl/pfi_queue.sv]
module pfi_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  pfi_pkg::work_type in_work,
   output logic out_valid,
   input  logic out_ready,
   output pfi_pkg::work_type out_work
);
   import pfi_pkg::*;

   work_type slot_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic push_w, pop_w;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_work = slot_ff[rd_ff];
   assign push_w = in_valid && in_ready;
   assign pop_w = out_valid && out_ready;

   // two-entry queue
   always_ff @(posedge clock) begin
      if (push_w) slot_ff[wr_ff] <= in_work;
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push_w) wr_ff <= ~wr_ff;
         if (pop_w) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push_w} - {1'b0, pop_w};
      end
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wr_ff == rd_ff)
      else $error("queue pointers disagree with count");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop_w) |=> cnt_ff == 2'd2) else $error("full queue lost entry");
endmodule

[hw/rtl/pfi_back.sv]
module pfi_back #(
   parameter int unsigned ENTRIES = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  pfi_pkg::work_type in_work,
   output logic out_valid,
   input  logic out_ready,
   output pfi_pkg::rsp_type out_rsp
);
   import pfi_pkg::*;

   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned EW = 3 * (ChanW + 3 * AccW);
   localparam int unsigned ModShift = IdxW + AW;
   localparam int unsigned ModMul = (1 << ModShift) / ENTRIES + 1;
   localparam int unsigned ModMulW = IdxW + 2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CALC,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [2:0][ChanW-1:0] rgb;
      logic [2:0][AccW-1:0] quo;
      logic [2:0][AccW-1:0] rem;
      logic [2:0][AccW-1:0] acc;
   } entry_type;

   entry_type mem [ENTRIES];
   entry_type rd_ff;
   entry_type wr_w;
   work_type work_ff;
   state_type state_ff;
   logic [AW-1:0] addr_w;
   rsp_type rsp_ff;
   logic [AccW-1:0] steps_w;
   logic [AccW-1:0] sum_w [3];
   logic [AccW-1:0] acc_w [3];
   logic signed [AccW+1:0] v_w [3];

   // entry number wraps modulo ENTRIES, quotient by reciprocal multiplication
   always_comb begin
      logic [IdxW+ModMulW-1:0] prod;
      logic [IdxW-1:0] quot;
      logic [IdxW+AW:0] t;
      prod = (IdxW+ModMulW)'(work_ff.index) * (IdxW+ModMulW)'(ModMul);
      quot = IdxW'(prod >> ModShift);
      t = (IdxW+AW+1)'(work_ff.index) - (IdxW+AW+1)'(quot) * (IdxW+AW+1)'(ENTRIES);
      addr_w = AW'(t);
   end

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign out_rsp = rsp_ff;
   assign steps_w = AccW'(work_ff.steps);

   // load builds signed quotient and remainder; step applies them
   always_comb begin
      wr_w = rd_ff;
      for (int c = 0; c < 3; c++) begin
         sum_w[c] = rd_ff.acc[c] + rd_ff.rem[c];
         acc_w[c] = sum_w[c];
         v_w[c] = $signed({{(AccW+2-ChanW){1'b0}}, rd_ff.rgb[c]})
            - $signed({rd_ff.quo[c][AccW-1], rd_ff.quo[c][AccW-1], rd_ff.quo[c]});
         if ($signed(sum_w[c]) >= $signed(steps_w)) begin
            acc_w[c] = sum_w[c] - steps_w;
            v_w[c] = v_w[c] - (AccW+2)'(1);
         end else if ($signed(sum_w[c]) <= -$signed(steps_w)) begin
            acc_w[c] = sum_w[c] + steps_w;
            v_w[c] = v_w[c] + (AccW+2)'(1);
         end
         if (work_ff.op == OP_LOAD) begin
            wr_w.rgb[c] = work_ff.start[c];
            wr_w.quo[c] = work_ff.neg[c] ? -AccW'(work_ff.quo[c]) : AccW'(work_ff.quo[c]);
            wr_w.rem[c] = work_ff.neg[c] ? -AccW'(work_ff.rem[c]) : AccW'(work_ff.rem[c]);
            wr_w.acc[c] = '0;
         end else begin
            wr_w.acc[c] = acc_w[c];
            if (v_w[c] < 0) wr_w.rgb[c] = '0;
            else if (v_w[c] > 63) wr_w.rgb[c] = '1;
            else wr_w.rgb[c] = v_w[c][ChanW-1:0];
         end
      end
   end

   // entry store, one read and one write port
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) rd_ff <= mem[addr_w];
      if (state_ff == S_CALC) mem[addr_w] <= wr_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (in_valid) begin
               work_ff <= in_work;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_CALC;
            S_CALC: begin
               rsp_ff.index <= work_ff.index;
               rsp_ff.rgb <= wr_w.rgb;
               state_ff <= S_OUT;
            end
            S_OUT: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> state_ff == S_CALC) else $error("read not followed by update");
   a_idle_rdy: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> !out_valid) else $error("back takes work while result pending");
   a_ew: assert property (@(posedge clock) $bits(entry_type) == EW) else $error("entry width");
endmodule

[hw/rtl/palette_fade_interpolator_top.sv]
// a load passes the front's 6 divide steps (S_DIV), then the back's S_READ, S_CALC and S_OUT
// states; a step skips the divider. The front and the back each finish one request before taking
// the next, the front for its restoring divider, the back for the read-modify-write of the entry store
// the front and back run overlapped through a two-entry queue
// reset: synchronous active high; clears control state, fade_steps goes to 32
// entry store is not cleared; entries are undefined until loaded
module palette_fade_interpolator_top #(
   parameter int unsigned ENTRIES = 256
) (
   input logic clock,
   input logic reset,
   pfi_req_if.sink req,
   pfi_rsp_if.source rsp,
   pfi_csr_if.sink csr
);
   import pfi_pkg::*;

   logic [StepsW-1:0] steps_ff;
   req_type req_w;
   work_type fw_w, qw_w;
   rsp_type rsp_w;
   logic f_v, f_r, q_v, q_r;

   // step count register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) steps_ff <= StepsReset;
      else if (csr.valid) steps_ff <= csr.fade_steps;
   end

   assign req_w.op = op_type'(req.operation);
   assign req_w.index = req.entry_index;
   assign req_w.start = {req.start_blue, req.start_green, req.start_red};
   assign req_w.target = {req.target_blue, req.target_green, req.target_red};

   pfi_front u_front (.clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .in_req(req_w), .steps(steps_ff), .out_valid(f_v), .out_ready(f_r), .out_work(fw_w));

   pfi_queue u_queue (.clock, .reset, .in_valid(f_v), .in_ready(f_r), .in_work(fw_w),
      .out_valid(q_v), .out_ready(q_r), .out_work(qw_w));

   pfi_back #(.ENTRIES(ENTRIES)) u_back (.clock, .reset, .in_valid(q_v), .in_ready(q_r),
      .in_work(qw_w), .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(rsp_w));

   assign rsp.out_index = rsp_w.index;
   assign rsp.out_red = rsp_w.rgb[0];
   assign rsp.out_green = rsp_w.rgb[1];
   assign rsp.out_blue = rsp_w.rgb[2];
   assign rsp.packed_colour = pack565(rsp_w.rgb);

   a_cfg_reset: assert property (@(posedge clock) reset |=> steps_ff == StepsReset)
      else $error("step count not reset");
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      csr.valid |=> steps_ff == $past(csr.fade_steps)) else $error("step count write lost");
   a_pack: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.packed_colour[10:5] == rsp.out_green) else $error("packing wrong");
endmodule

[bench/tb_palette_fade_interpolator_top.sv]
module tb_palette_fade_interpolator_top;
   import pfi_pkg::*;

   localparam int Entries = 256;
   localparam int CycleLimit = 3000000;

   // predicted result of one request
   typedef struct {
      logic [7:0] index;
      logic [5:0] red;
      logic [5:0] green;
      logic [5:0] blue;
      logic [15:0] packed_colour;
   } colour_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfi_req_if req ();
   pfi_rsp_if rsp ();
   pfi_csr_if csr ();

   palette_fade_interpolator_top #(.ENTRIES(Entries)) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // shadow palette
   logic [6:0] steps_shadow;
   int level_now[Entries][3];
   int quo_now[Entries][3];
   int rem_now[Entries][3];
   int acc_now[Entries][3];
   bit loaded[Entries];
   colour_type colour_queue[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int mismatches;
   int cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int wrap_acc(int v);
      logic [20:0] u;
      u = v[20:0];
      return int'($signed(u));
   endfunction

   // fade arithmetic for one request, pushing the expected colour
   function automatic void predict_colour(logic op, logic [7:0] idx,
                                          logic [2:0][5:0] st, logic [2:0][5:0] tg);
      int e, n, d, v, a;
      colour_type c;
      int lv[3];
      e = idx % Entries;
      n = (steps_shadow == 0) ? 1 : int'(steps_shadow);
      for (int ch = 0; ch < 3; ch++) begin
         if (op == OP_LOAD) begin
            d = int'(st[ch]) - int'(tg[ch]);
            level_now[e][ch] = st[ch];
            quo_now[e][ch] = wrap_acc(d / n);
            rem_now[e][ch] = wrap_acc(d % n);
            acc_now[e][ch] = 0;
         end else begin
            v = level_now[e][ch] - quo_now[e][ch];
            a = wrap_acc(acc_now[e][ch] + rem_now[e][ch]);
            if (a >= n) begin
               a -= n;
               v -= 1;
            end else if (a <= -n) begin
               a += n;
               v += 1;
            end
            if (v < 0) v = 0;
            if (v > 63) v = 63;
            level_now[e][ch] = v;
            acc_now[e][ch] = wrap_acc(a);
         end
         lv[ch] = level_now[e][ch];
      end
      if (op == OP_LOAD) loaded[e] = 1'b1;
      c.index = idx;
      c.red = lv[0][5:0];
      c.green = lv[1][5:0];
      c.blue = lv[2][5:0];
      c.packed_colour = {c.red[5:1], c.green, c.blue[5:1]};
      colour_queue.push_back(c);
   endfunction

   // drive one request and wait for its handshake; valid stays up for the next one
   task automatic send_request(logic op, logic [7:0] idx,
                               logic [2:0][5:0] st, logic [2:0][5:0] tg);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.operation <= op;
      req.entry_index <= idx;
      req.start_red <= st[0];
      req.start_green <= st[1];
      req.start_blue <= st[2];
      req.target_red <= tg[0];
      req.target_green <= tg[1];
      req.target_blue <= tg[2];
      do @(posedge clock); while (!req.ready);
      predict_colour(op, idx, st, tg);
   endtask

   task automatic send_load(logic [7:0] idx, logic [2:0][5:0] st, logic [2:0][5:0] tg);
      send_request(OP_LOAD, idx, st, tg);
   endtask

   task automatic send_step(logic [7:0] idx);
      send_request(OP_STEP, idx, '0, '0);
   endtask

   function automatic logic [2:0][5:0] random_colour();
      logic [2:0][5:0] c;
      for (int ch = 0; ch < 3; ch++) c[ch] = 6'($urandom_range(63));
      return c;
   endfunction

   // wait for the block to drain, then write the step count
   task automatic write_steps(logic [6:0] value);
      req.valid <= 1'b0;
      while (colour_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr.valid <= 1'b1;
      csr.fade_steps <= value;
      do @(posedge clock); while (!csr.ready);
      steps_shadow = value;
      csr.valid <= 1'b0;
   endtask

   // extremes of colours and indexes, fade past the count, unusual counts
   task automatic test_directed();
      send_load(8'd0, {6'd63, 6'd63, 6'd63}, {6'd0, 6'd0, 6'd0});
      send_load(8'd255, {6'd0, 6'd0, 6'd0}, {6'd63, 6'd63, 6'd63});
      send_load(8'd17, {6'd10, 6'd33, 6'd42}, {6'd10, 6'd33, 6'd42});
      repeat (3) send_step(8'd0);
      repeat (3) send_step(8'd255);
      send_step(8'd17);
      write_steps(7'd1);
      send_load(8'd5, {6'd63, 6'd0, 6'd21}, {6'd0, 6'd63, 6'd50});
      repeat (3) send_step(8'd5);
      write_steps(7'd0);
      send_load(8'd6, {6'd40, 6'd1, 6'd62}, {6'd3, 6'd60, 6'd2});
      send_step(8'd6);
      send_step(8'd6);
      write_steps(7'd127);
      send_load(8'd7, {6'd63, 6'd0, 6'd31}, {6'd0, 6'd63, 6'd32});
      send_step(8'd7);
      // count changed mid-fade
      write_steps(7'd3);
      send_step(8'd7);
      send_step(8'd0);
      write_steps(7'd64);
   endtask

   // fades on random entries, mostly loaded ones, under various counts
   task automatic test_random(int count);
      int e;
      for (int i = 0; i < count; i++) begin
         if (i % 400 == 399) begin
            case ($urandom_range(3))
               0: write_steps(7'd1);
               1: write_steps(7'd64);
               2: write_steps(7'd127);
               default: write_steps(7'($urandom_range(127)));
            endcase
         end
         e = $urandom_range(7) == 0 ? $urandom_range(255) : $urandom_range(15);
         if (!loaded[e] || $urandom_range(5) == 0)
            send_load(8'(e), random_colour(), random_colour());
         else
            send_step(8'(e));
      end
   endtask

   // receiver stops for a long stretch while requests keep coming
   task automatic test_backpressure();
      hold_cycles = 300;
      for (int i = 0; i < 40; i++) begin
         if (loaded[i % 16]) send_step(8'(i % 16));
         else send_load(8'(i % 16), random_colour(), random_colour());
      end
   endtask

   // result checker
   always @(posedge clock) begin
      colour_type c;
      if (!reset && rsp.valid && rsp.ready) begin
         if (colour_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result index %0d", rsp.out_index);
         end else begin
            c = colour_queue.pop_front();
            if (rsp.out_index !== c.index || rsp.out_red !== c.red
                || rsp.out_green !== c.green || rsp.out_blue !== c.blue
                || rsp.packed_colour !== c.packed_colour) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %0d %0d %0d %0d %h got %0d %0d %0d %0d %h",
                     c.index, c.red, c.green, c.blue, c.packed_colour, rsp.out_index,
                     rsp.out_red, rsp.out_green, rsp.out_blue, rsp.packed_colour);
            end
         end
      end
   end

   // receiver readiness, with the long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.operation = OP_LOAD;
      req.entry_index = '0;
      req.start_red = '0;
      req.start_green = '0;
      req.start_blue = '0;
      req.target_red = '0;
      req.target_green = '0;
      req.target_blue = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.fade_steps = '0;
      steps_shadow = StepsReset;
      mismatches = 0;
      cycle_count = 0;
      hold_cycles = 0;
      send_idle_pct = 6;
      recv_idle_pct = 68;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      test_backpressure();
      send_idle_pct = 68;
      recv_idle_pct = 6;
      test_random(700);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(700);
      req.valid <= 1'b0;
      while (colour_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && colour_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/pfi_pkg.sv
hw/rtl/pfi_if.sv
hw/rtl/pfi_front.sv
hw/rtl/pfi_queue.sv
hw/rtl/pfi_back.sv
hw/rtl/palette_fade_interpolator_top.sv
bench/tb_palette_fade_interpolator_top.sv
